>>> src/gdw_pkg.sv
// ----------------------------------------------------------------------------
// gdw_pkg
// shared constants, status codes and calendar helpers for the weekday block
// ----------------------------------------------------------------------------
`default_nettype none

package gdw_pkg;

  localparam int DAY_W    = 6;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 14;
  localparam int STATUS_W = 3;
  localparam int WDAY_W   = 3;
  localparam int COUNT_W  = 22;
  // exact count before saturation
  localparam int SUM_W    = 23;
  // days since the first year, per-year part
  localparam int DAYS_Y_W = 23;
  localparam int LEAPS_W  = 12;
  localparam int DOY_W    = 9;
  localparam int Q4_W     = YEAR_W - 2;
  localparam int Q25_W    = 8;

  localparam logic [YEAR_W-1:0]  FIRST_YEAR    = YEAR_W'(1584);
  localparam logic [COUNT_W-1:0] DAY_COUNT_MAX = {COUNT_W{1'b1}};
  // leap years in 1..1583
  localparam logic [LEAPS_W-1:0] LEAPS_BASE    = LEAPS_W'(383);
  // reciprocal of 25, exact for 12-bit dividends
  localparam int                 RECIP25_SH    = 17;
  localparam logic [12:0]        RECIP25       = 13'd5243;
  localparam logic [8:0]         DAYS_PER_YEAR = 9'd365;

  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   FEB_LEAP_LEN = DAY_W'(29);

  localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_YEAR     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_MONTH    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_DAY      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FEB29_COMMON = 3'd4;

  // month length, february taken as 29
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd2:                     len = 6'd29;
      4'd4, 4'd6, 4'd9, 4'd11:  len = 6'd30;
      default:                  len = 6'd31;
    endcase
    return len;
  endfunction

  // days before the first of a month in a common year
  function automatic logic [DOY_W-1:0] days_before(input logic [MONTH_W-1:0] m);
    logic [DOY_W-1:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // mod 7 by folding octal digits, since 8 is 1 mod 7
  function automatic logic [WDAY_W-1:0] mod7(input logic [SUM_W-1:0] x);
    logic [23:0] xp;
    logic [5:0]  s;
    logic [3:0]  a;
    logic [3:0]  b;
    xp = {1'b0, x};
    s  = 6'd0;
    for (int i = 0; i < 8; i++) begin
      s = s + 6'(xp[3*i +: 3]);
    end
    a = 4'(s[5:3]) + 4'(s[2:0]);
    b = 4'(a[3]) + 4'(a[2:0]);
    return (b == 4'd7) ? 3'd0 : b[2:0];
  endfunction

endpackage

`default_nettype wire

>>> src/gdw_year_unit.sv
// ----------------------------------------------------------------------------
// gdw_year_unit
// year arithmetic: leap flag after one stage, leap years passed and
// whole-year days after two
// ----------------------------------------------------------------------------
`default_nettype none

module gdw_year_unit (
  input  wire                            clk,
  input  wire  [gdw_pkg::YEAR_W-1:0]     year,
  output logic                           leap,
  output logic [gdw_pkg::LEAPS_W-1:0]    leaps,
  output logic [gdw_pkg::DAYS_Y_W-1:0]   days_y
);
  import gdw_pkg::*;

  // stage a
  logic [YEAR_W-1:0]  ym1;
  logic [Q4_W-1:0]    q4m1_nxt;
  logic [Q4_W-1:0]    y4;
  logic [24:0]        prod_m1;
  logic [24:0]        prod_y;
  logic [Q4_W-1:0]    q4m1_r;
  logic [Q25_W-1:0]   q100_r;
  logic [Q25_W-1:0]   yq25_r;
  logic [Q4_W-1:0]    y4_r;
  logic               div4_r;
  logic [YEAR_W-1:0]  yoff_r;

  // stage b
  logic [Q25_W+4:0]   yq25x25;
  logic               rem25_zero;
  logic               leap_nxt;
  logic [LEAPS_W-1:0] leaps_nxt;
  logic [DAYS_Y_W-1:0] days_y_nxt;

  assign ym1      = year - YEAR_W'(1);
  assign q4m1_nxt = ym1[YEAR_W-1:2];
  assign y4       = year[YEAR_W-1:2];
  assign prod_m1  = 25'(q4m1_nxt) * 25'(RECIP25);
  assign prod_y   = 25'(y4) * 25'(RECIP25);

  always_ff @(posedge clk) begin
    q4m1_r <= q4m1_nxt;
    q100_r <= prod_m1[RECIP25_SH +: Q25_W];
    yq25_r <= prod_y[RECIP25_SH +: Q25_W];
    y4_r   <= y4;
    div4_r <= (year[1:0] == 2'b00);
    yoff_r <= year - FIRST_YEAR;
  end

  // with the year a multiple of 4, y4 mod 25 zero means the year is a multiple of 100
  assign yq25x25    = ({5'd0, yq25_r} << 4) + ({5'd0, yq25_r} << 3) + {5'd0, yq25_r};
  assign rem25_zero = (13'(y4_r) == yq25x25);
  assign leap_nxt   = div4_r && (!rem25_zero || (yq25_r[1:0] == 2'b00));
  assign leaps_nxt  = LEAPS_W'(q4m1_r) - LEAPS_W'(q100_r) + LEAPS_W'(q100_r[Q25_W-1:2])
                    - LEAPS_BASE;
  assign days_y_nxt = DAYS_Y_W'(yoff_r) * DAYS_Y_W'(DAYS_PER_YEAR);

  // leap flag lines up with the first stage of the caller
  assign leap = leap_nxt;

  always_ff @(posedge clk) begin
    leaps  <= leaps_nxt;
    days_y <= days_y_nxt;
  end

endmodule

`default_nettype wire

>>> src/gregorian_date_to_weekday.sv
// ----------------------------------------------------------------------------
// gregorian_date_to_weekday
// checks a gregorian date and gives its day count from 1584-01-01 and weekday
// ----------------------------------------------------------------------------
// throughput: one item per cycle, busy is always low, no stall on either side
// the four stages are range checks with year arithmetic, day-of-year and status, sum, mod 7
// the receiver cannot stall: each result shows for exactly one cycle
// reset (rst_n low, synchronous) clears the stage valid bits, items in flight
// are dropped
`default_nettype none

module gregorian_date_to_weekday (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             start,
  output logic                            busy,
  input  wire  [gdw_pkg::DAY_W-1:0]       in_day_of_month,
  input  wire  [gdw_pkg::MONTH_W-1:0]     in_month_number,
  input  wire  [gdw_pkg::YEAR_W-1:0]      in_year_number,
  output logic                            out_valid,
  output logic [gdw_pkg::STATUS_W-1:0]    out_status,
  output logic [gdw_pkg::WDAY_W-1:0]      out_weekday,
  output logic [gdw_pkg::COUNT_W-1:0]     out_day_count
);
  import gdw_pkg::*;

  // stage 1: range checks on the raw fields
  logic                s1_vld_r;
  logic                s1_bad_year_r;
  logic                s1_bad_month_r;
  logic                s1_bad_day_r;
  logic                s1_feb29_r;
  logic [MONTH_W-1:0]  s1_month_r;
  logic [DAY_W-1:0]    s1_day_r;
  logic                bad_month_nxt;
  logic                bad_day_nxt;

  // stage 2: status and day of year, year terms from the year unit
  logic                leap;
  logic [LEAPS_W-1:0]  leaps;
  logic [DAYS_Y_W-1:0] days_y;
  logic                s2_vld_r;
  logic [STATUS_W-1:0] s2_status_r;
  logic [DOY_W-1:0]    s2_doy_r;
  logic [STATUS_W-1:0] status_nxt;
  logic [DOY_W-1:0]    doy_nxt;
  logic                s2_vld_nxt;

  // stage 3: exact count
  logic                s3_vld_r;
  logic [STATUS_W-1:0] s3_status_r;
  logic [SUM_W-1:0]    s3_count_r;
  logic [SUM_W-1:0]    count_nxt;

  // stage 4: weekday and saturation, zeroed for a bad date
  logic                out_vld_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [WDAY_W-1:0]   out_wday_r;
  logic [COUNT_W-1:0]  out_count_r;
  logic                ok3;
  logic [WDAY_W-1:0]   wday_nxt;
  logic [COUNT_W-1:0]  sat_nxt;

  // fully pipelined, never holds off an item
  assign busy = 1'b0;

  // stage 1 ------------------------------------------------------------------
  assign bad_month_nxt = (in_month_number == '0) || (in_month_number > MONTH_DEC);
  // february allows 29 here, the common-year case is settled once leap is known
  assign bad_day_nxt   = (in_day_of_month == '0)
                      || (in_day_of_month > month_len(in_month_number));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_bad_year_r  <= (in_year_number < FIRST_YEAR);
    s1_bad_month_r <= bad_month_nxt;
    s1_bad_day_r   <= bad_day_nxt;
    s1_feb29_r     <= (in_month_number == MONTH_FEB) && (in_day_of_month == FEB_LEAP_LEN);
    s1_month_r     <= in_month_number;
    s1_day_r       <= in_day_of_month;
  end

  // year arithmetic runs alongside stages 1 and 2
  gdw_year_unit u_year (
    .clk    (clk),
    .year   (in_year_number),
    .leap   (leap),
    .leaps  (leaps),
    .days_y (days_y)
  );

  // stage 2 ------------------------------------------------------------------
  // checks in priority order: year, month, day, february 29
  always_comb begin
    if (s1_bad_year_r) begin
      status_nxt = ST_BAD_YEAR;
    end else if (s1_bad_month_r) begin
      status_nxt = ST_BAD_MONTH;
    end else if (s1_bad_day_r) begin
      status_nxt = ST_BAD_DAY;
    end else if (s1_feb29_r && !leap) begin
      status_nxt = ST_FEB29_COMMON;
    end else begin
      status_nxt = ST_OK;
    end
  end

  // day within the year, one extra after february in a leap year
  assign doy_nxt = days_before(s1_month_r) + DOY_W'(s1_day_r)
                 + DOY_W'(leap && (s1_month_r > MONTH_FEB));
  assign s2_vld_nxt = s1_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s2_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s2_status_r <= status_nxt;
    s2_doy_r    <= doy_nxt;
  end

  // stage 3 ------------------------------------------------------------------
  // year terms from the unit are aligned with stage 2 registers
  assign count_nxt = days_y + SUM_W'(leaps) + SUM_W'(s2_doy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_status_r <= s2_status_r;
    s3_count_r  <= count_nxt;
  end

  // stage 4 ------------------------------------------------------------------
  // weekday from the exact count, day_count saturates for far-off years
  assign ok3      = (s3_status_r == ST_OK);
  assign wday_nxt = ok3 ? mod7(s3_count_r) : '0;
  assign sat_nxt  = !ok3 ? '0
                  : (s3_count_r[SUM_W-1:COUNT_W] != '0) ? DAY_COUNT_MAX
                  : s3_count_r[COUNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= s3_status_r;
    out_wday_r   <= wday_nxt;
    out_count_r  <= sat_nxt;
  end

  assign out_valid     = out_vld_r;
  assign out_status    = out_status_r;
  assign out_weekday   = out_wday_r;
  assign out_day_count = out_count_r;

  // checks -------------------------------------------------------------------
  // every accepted item comes out as an out_valid strobe
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##4 out_valid)
    else $error("item lost in pipeline");

  // no result without a start pulse before it
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 4))
    else $error("result without an item");

  // a rejected date carries zero count and weekday
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_day_count == '0) && (out_weekday == '0))
    else $error("nonzero fields on a rejected date");

  // a valid date has a nonzero count and a weekday below seven
  a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OK) |-> (out_day_count != '0) && (out_weekday != 3'd7))
    else $error("out-of-range fields on a valid date");

endmodule

`default_nettype wire

>>> dv/gregorian_date_to_weekday_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_to_weekday_test
// drives dates into the weekday block and checks status, weekday and count
// ----------------------------------------------------------------------------
// a directed set covers the calendar edges: the first year, the leap rule
// with its century exceptions, every rejection path and the saturated day
// count, then random bursts of mostly well-formed dates follow, mixed with
// broken dates and raw noise; every accepted date is predicted in a small
// scoreboard and each out_valid strobe is checked against the oldest entry
// ----------------------------------------------------------------------------

module gregorian_date_to_weekday_test;

  import gdw_pkg::*;

  // one predicted answer, with the date kept for messages
  typedef struct {
    logic [DAY_W-1:0]    day;
    logic [MONTH_W-1:0]  month;
    logic [YEAR_W-1:0]   year;
    logic [STATUS_W-1:0] status;
    logic [WDAY_W-1:0]   weekday;
    logic [COUNT_W-1:0]  day_count;
  } date_verdict_t;

  // gregorian leap rule
  function automatic bit leap_rule(input int unsigned y);
    return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
  endfunction

  // leap years in 1..n, closed form
  function automatic int unsigned leaps_through(input int unsigned n);
    return n / 4 - n / 100 + n / 400;
  endfunction

  // length of a month in the given year, 31 for anything out of range
  function automatic int unsigned month_days(input logic [MONTH_W-1:0] m,
                                             input int unsigned y);
    int unsigned len;
    case (m)
      MONTH_FEB:                len = leap_rule(y) ? 29 : 28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 30;
      default:                  len = 31;
    endcase
    return len;
  endfunction

  // --------------------------------------------------------------------------
  // scoreboard: dates go in at acceptance, results are matched in order
  // --------------------------------------------------------------------------
  class weekday_ledger;
    date_verdict_t pending[$];
    int failures;
    int shown;
    int checked;
    int saturated;
    int per_status[5];

    function date_verdict_t predict_verdict(input logic [DAY_W-1:0] d,
                                            input logic [MONTH_W-1:0] m,
                                            input logic [YEAR_W-1:0] y);
      date_verdict_t v;
      int unsigned total;
      v.day = d;
      v.month = m;
      v.year = y;
      v.status = ST_OK;
      v.weekday = '0;
      v.day_count = '0;
      // checks run year, month, day; february is first held to 29 days
      if (y < FIRST_YEAR)
        v.status = ST_BAD_YEAR;
      else if (m == 0 || m > MONTH_DEC)
        v.status = ST_BAD_MONTH;
      else if (d == 0 || d > month_days(m, 2000))
        v.status = ST_BAD_DAY;
      else if (m == MONTH_FEB && d == FEB_LEAP_LEN && !leap_rule(y))
        v.status = ST_FEB29_COMMON;
      if (v.status == ST_OK) begin
        total = (int'(y) - int'(FIRST_YEAR)) * 365
              + leaps_through(y - 1) - leaps_through(FIRST_YEAR - 1) + d;
        for (int k = 1; k < m; k++) begin
          total += month_days(MONTH_W'(k), y);
        end
        // weekday from the exact count, the count field clips
        v.weekday = WDAY_W'(total % 7);
        v.day_count = (total > DAY_COUNT_MAX) ? DAY_COUNT_MAX : COUNT_W'(total);
      end
      return v;
    endfunction

    function void note_date(input logic [DAY_W-1:0] d, input logic [MONTH_W-1:0] m,
                            input logic [YEAR_W-1:0] y);
      pending.push_back(predict_verdict(d, m, y));
    endfunction

    function void check_result(input logic [STATUS_W-1:0] st,
                               input logic [WDAY_W-1:0] wd,
                               input logic [COUNT_W-1:0] cnt);
      date_verdict_t v;
      if (pending.size() == 0) begin
        failures++;
        if (shown < 10)
          $display("unexpected result: status %0d weekday %0d count %0d", st, wd, cnt);
        shown++;
        return;
      end
      v = pending.pop_front();
      checked++;
      if (v.status <= ST_FEB29_COMMON)
        per_status[v.status]++;
      if (v.status == ST_OK && v.day_count == DAY_COUNT_MAX)
        saturated++;
      if (st !== v.status || wd !== v.weekday || cnt !== v.day_count) begin
        failures++;
        if (shown < 10)
          $display("mismatch %0d-%0d-%0d: status %0d/%0d weekday %0d/%0d count %0d/%0d",
                   v.year, v.month, v.day, v.status, st, v.weekday, wd,
                   v.day_count, cnt);
        shown++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // block under test
  // --------------------------------------------------------------------------
  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [DAY_W-1:0]    in_day_of_month;
  logic [MONTH_W-1:0]  in_month_number;
  logic [YEAR_W-1:0]   in_year_number;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [WDAY_W-1:0]   out_weekday;
  logic [COUNT_W-1:0]  out_day_count;

  weekday_ledger ledger;

  gregorian_date_to_weekday u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_day_of_month (in_day_of_month),
    .in_month_number (in_month_number),
    .in_year_number  (in_year_number),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_weekday     (out_weekday),
    .out_day_count   (out_day_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs or loses strobes
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // results cannot be held off, so every strobe is checked at its edge
  always @(posedge clk) begin
    if (rst_n && out_valid)
      ledger.check_result(out_status, out_weekday, out_day_count);
  end

  // --------------------------------------------------------------------------
  // driver tasks, entered and left at a falling edge
  // --------------------------------------------------------------------------

  // present one date and hold it until the block takes it
  task automatic send_date(input logic [DAY_W-1:0] d, input logic [MONTH_W-1:0] m,
                           input logic [YEAR_W-1:0] y);
    start           <= 1'b1;
    in_day_of_month <= d;
    in_month_number <= m;
    in_year_number  <= y;
    @(posedge clk);
    while (busy) begin
      @(negedge clk);
      @(posedge clk);
    end
    ledger.note_date(d, m, y);
    @(negedge clk);
  endtask

  // sender gap, with junk on the fields that must be ignored
  task automatic idle_for(input int cycles);
    repeat (cycles) begin
      start           <= 1'b0;
      in_day_of_month <= DAY_W'($urandom);
      in_month_number <= MONTH_W'($urandom);
      in_year_number  <= YEAR_W'($urandom);
      @(negedge clk);
    end
  endtask

  // year pick biased toward the first years, centuries and the top of range
  function automatic logic [YEAR_W-1:0] pick_year();
    int unsigned y;
    case ($urandom_range(0, 9))
      0:       y = $urandom_range(1584, 1604);
      1:       y = 100 * $urandom_range(16, 99);
      2:       y = $urandom_range(9980, 9999);
      default: y = $urandom_range(1584, 9999);
    endcase
    return YEAR_W'(y);
  endfunction

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int sent;
    int burst;
    int guard;
    logic [DAY_W-1:0]   d;
    logic [MONTH_W-1:0] m;
    logic [YEAR_W-1:0]  y;

    ledger          = new();
    rst_n           = 1'b0;
    start           = 1'b0;
    in_day_of_month = '0;
    in_month_number = '0;
    in_year_number  = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: first day, year edge, all-zero and all-one fields
    send_date(6'd1,  4'd1,  14'd1584);
    send_date(6'd31, 4'd12, 14'd1583);
    send_date(6'd0,  4'd0,  14'd0);
    send_date(6'd63, 4'd15, 14'd16383);
    // bad months, day left unchecked
    send_date(6'd15, 4'd0,  14'd1584);
    send_date(6'd1,  4'd13, 14'd2000);
    send_date(6'd0,  4'd15, 14'd2000);
    // bad days against month lengths
    send_date(6'd0,  4'd1,  14'd2000);
    send_date(6'd32, 4'd1,  14'd2000);
    send_date(6'd31, 4'd4,  14'd2000);
    send_date(6'd63, 4'd12, 14'd2000);
    // leap rule: by 400, century exception, by 4, common year
    send_date(6'd29, 4'd2,  14'd2000);
    send_date(6'd29, 4'd2,  14'd1900);
    send_date(6'd28, 4'd2,  14'd1900);
    send_date(6'd29, 4'd2,  14'd2024);
    send_date(6'd29, 4'd2,  14'd2023);
    send_date(6'd30, 4'd2,  14'd2024);
    send_date(6'd1,  4'd3,  14'd2024);
    // top of the stated year range
    send_date(6'd31, 4'd12, 14'd9999);
    // day count around and past saturation, weekday still exact
    send_date(6'd1,  4'd1,  14'd13067);
    send_date(6'd31, 4'd12, 14'd13067);
    send_date(6'd15, 4'd6,  14'd13068);
    send_date(6'd31, 4'd12, 14'd16383);
    idle_for(3);

    // random: bursts of random length, gaps between, some long unbroken runs
    sent = 0;
    while (sent < 1600) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
      repeat (burst) begin
        case ($urandom_range(0, 99)) inside
          [0:59]: begin
            // well-formed date
            y = pick_year();
            m = MONTH_W'($urandom_range(1, 12));
            d = DAY_W'($urandom_range(1, month_days(m, y)));
          end
          [60:69]: begin
            // february 29, leap or not
            y = pick_year();
            m = MONTH_FEB;
            d = FEB_LEAP_LEN;
          end
          [70:79]: begin
            // day zero or past the month end
            y = pick_year();
            m = MONTH_W'($urandom_range(1, 12));
            d = ($urandom_range(0, 3) == 0) ? '0
                : DAY_W'($urandom_range(month_days(m, 2000) + 1, 63));
          end
          [80:87]: begin
            y = pick_year();
            m = ($urandom_range(0, 3) == 0) ? '0 : MONTH_W'($urandom_range(13, 15));
            d = DAY_W'($urandom);
          end
          [88:94]: begin
            y = YEAR_W'($urandom_range(0, 1583));
            m = MONTH_W'($urandom);
            d = DAY_W'($urandom);
          end
          default: begin
            // anything the ports can carry, often valid far past 9999
            y = YEAR_W'($urandom);
            if ($urandom_range(0, 1) == 0) begin
              if (y < FIRST_YEAR)
                y = y + FIRST_YEAR;
              m = MONTH_W'($urandom_range(1, 12));
              d = DAY_W'($urandom_range(1, month_days(m, y)));
            end else begin
              m = MONTH_W'($urandom);
              d = DAY_W'($urandom);
            end
          end
        endcase
        send_date(d, m, y);
        sent++;
      end
      if ($urandom_range(0, 9) >= 3)
        idle_for($urandom_range(1, 8));
    end

    // drain the pipeline, then keep watching for stray strobes
    start <= 1'b0;
    guard = 0;
    while (ledger.pending.size() != 0 && guard < 200) begin
      @(posedge clk);
      guard++;
    end
    repeat (10) @(posedge clk);
    ledger.failures += ledger.pending.size();

    $display("checked %0d dates: %0d valid, %0d bad year, %0d bad month, %0d bad day",
             ledger.checked, ledger.per_status[ST_OK], ledger.per_status[ST_BAD_YEAR],
             ledger.per_status[ST_BAD_MONTH], ledger.per_status[ST_BAD_DAY]);
    $display("%0d feb 29 in common years, %0d saturated counts, %0d failures",
             ledger.per_status[ST_FEB29_COMMON], ledger.saturated, ledger.failures);
    if (ledger.failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
